// ===== rtl/repc_pkg.sv =====
`default_nettype none
package repc_pkg;

	typedef struct packed {
		logic        operation;
		logic [11:0] position;
		logic [11:0] value;
		logic [11:0] left;
		logic [11:0] right;
	} repc_in_t;

	typedef struct packed {
		logic [22:0] numerator;
		logic [22:0] denominator;
		logic        range_error;
	} repc_out_t;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam int PAIR_W = 23;
	localparam int HIST_W = 13;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOVE_RD,
		ST_MOVE_HR,
		ST_MOVE_UPD,
		ST_DEN,
		ST_GCD,
		ST_DIV_A,
		ST_DIV_B,
		ST_DONE
	} repc_state_t;

	// Window edge moves, in the order a query applies them.
	typedef enum logic [2:0] {
		MV_NONE,
		MV_GROW_HIGH,
		MV_GROW_LOW,
		MV_SHRINK_HIGH,
		MV_SHRINK_LOW
	} repc_move_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       clear_step;
		logic       load_wr;
		logic       capture;
		logic       seq_rd;
		logic       hist_rd;
		logic       hist_upd;
		logic       den_calc;
		logic       gcd_init;
		logic       gcd_step;
		logic       div_init;
		logic       div_step;
		logic       result_out;
		logic       trivial_out;
	} repc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       clear_last;
		repc_move_t move;
		logic       trivial;
		logic       gcd_done;
		logic       div_done;
	} repc_stat_t;

endpackage
`default_nettype wire

// ===== rtl/repc_ctrl.sv =====
`default_nettype none
module repc_ctrl
	import repc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       operation,
	input  wire repc_stat_t stat,
	output logic            busy,
	output repc_cmd_t       cmd
);

	repc_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (operation == OP_LOAD) begin
						cmd.load_wr = 1'b1;
					end else begin
						cmd.capture = 1'b1;
						state_d = ST_MOVE_RD;
					end
				end
			end
			ST_MOVE_RD: begin
				if (stat.trivial) begin
					cmd.trivial_out = 1'b1;
					state_d = ST_DONE;
				end else if (stat.move == MV_NONE) begin
					state_d = ST_DEN;
				end else begin
					cmd.seq_rd = 1'b1;
					state_d = ST_MOVE_HR;
				end
			end
			ST_MOVE_HR: begin
				cmd.hist_rd = 1'b1;
				state_d = ST_MOVE_UPD;
			end
			ST_MOVE_UPD: begin
				cmd.hist_upd = 1'b1;
				state_d = ST_MOVE_RD;
			end
			ST_DEN: begin
				cmd.den_calc = 1'b1;
				state_d = ST_GCD;
			end
			ST_GCD: begin
				if (stat.gcd_done) begin
					cmd.div_init = 1'b1;
					state_d = ST_DIV_A;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIV_A: begin
				if (stat.div_done) begin
					cmd.result_out = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			ST_DIV_B: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (state_q == ST_GCD && !stat.gcd_done) begin
			// Zero numerator is caught in the datapath by the gcd step.
			state_d = ST_GCD;
		end
	end

`ifndef SYNTH
	a_no_cmd_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> busy)
		else $error("busy low during clear");
	a_upd_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hist_upd |-> $past(cmd.hist_rd))
		else $error("update without read");
	a_hr_after_sr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hist_rd |-> $past(cmd.seq_rd))
		else $error("histogram read without sequence read");
`endif

endmodule
`default_nettype wire

// ===== rtl/repc_dp.sv =====
`default_nettype none
module repc_dp
	import repc_pkg::*;
#(
	parameter int SEQ_DEPTH   = 4096,
	parameter int VALUE_COUNT = 4096
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire repc_in_t  in_item,
	input  wire repc_cmd_t cmd,
	output repc_stat_t     stat,
	output logic           done,
	output repc_out_t      res
);

	localparam int SA = $clog2(SEQ_DEPTH);
	localparam int VA = $clog2(VALUE_COUNT);
	localparam int PW = SA + 1;
	localparam logic signed [PW:0] W_ONE = (PW + 1)'(1);

	// Memories: sequence store and histogram.
	logic [11:0]       seq_mem [SEQ_DEPTH];
	logic [HIST_W-1:0] hist_mem [VALUE_COUNT];

	logic [SA-1:0]       rd_pos;
	logic [11:0]         seq_rd_q;
	logic [HIST_W-1:0]   hist_rd_q;
	logic [VA-1:0]       val_q;
	logic [VA-1:0]       clr_q;
	logic                started_q;
	logic signed [PW:0]  wlo_q, whi_q;
	logic [SA-1:0]       lq_q, rq_q;
	logic                trivial_q, err_q;
	logic [PAIR_W-1:0]   pair_q;
	repc_move_t          move_q;
	logic [PAIR_W-1:0]   ga_q, gb_q;
	logic [PAIR_W-1:0]   num_q, den_q;
	logic [PAIR_W-1:0]   qn_q, qd_q;
	logic [4:0]          bit_q;
	logic                gdone_q;
	logic [PAIR_W-1:0]   g_q;
	logic [PAIR_W:0]     rn_q, rd_q;
	logic [11:0]         lsat, rsat;
	logic [HIST_W-1:0]   hist_new;
	logic                load_ok;
	logic [PAIR_W:0]     rn_sh, rd_sh;

	// Saturate query edges to the store.
	always_comb begin
		lsat = (32'(in_item.left) > SEQ_DEPTH - 1) ? 12'(SEQ_DEPTH - 1) : in_item.left;
		rsat = (32'(in_item.right) > SEQ_DEPTH - 1) ? 12'(SEQ_DEPTH - 1) : in_item.right;
		load_ok = !started_q && (32'(in_item.position) < SEQ_DEPTH)
			&& (32'(in_item.value) < VALUE_COUNT);
	end

	// Choose the next edge move.
	always_comb begin
		if (whi_q < $signed({2'b00, rq_q})) begin
			move_q = MV_GROW_HIGH;
			rd_pos = SA'(whi_q + 1);
		end else if (wlo_q > $signed({2'b00, lq_q})) begin
			move_q = MV_GROW_LOW;
			rd_pos = SA'(wlo_q - 1);
		end else if (whi_q > $signed({2'b00, rq_q})) begin
			move_q = MV_SHRINK_HIGH;
			rd_pos = SA'(whi_q);
		end else if (wlo_q < $signed({2'b00, lq_q})) begin
			move_q = MV_SHRINK_LOW;
			rd_pos = SA'(wlo_q);
		end else begin
			move_q = MV_NONE;
			rd_pos = '0;
		end
	end

	logic grow;
	repc_move_t cur_move_q;
	assign grow = (cur_move_q == MV_GROW_HIGH) || (cur_move_q == MV_GROW_LOW);
	assign hist_new = grow ? hist_rd_q + 1'b1 : hist_rd_q - 1'b1;

	// Sequence store.
	always_ff @(posedge clk) begin
		if (cmd.load_wr && load_ok) begin
			seq_mem[SA'(in_item.position)] <= in_item.value;
		end
		if (cmd.seq_rd) begin
			seq_rd_q <= seq_mem[rd_pos];
		end
	end

	// Histogram, cleared by a sweep after reset.
	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			hist_mem[clr_q] <= '0;
		end else if (cmd.hist_upd) begin
			hist_mem[val_q] <= hist_new;
		end
		if (cmd.hist_rd) begin
			hist_rd_q <= hist_mem[VA'(seq_rd_q)];
		end
	end

	// Control state of the window and pair count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			started_q <= 1'b0;
			wlo_q     <= '0;
			whi_q     <= '1;
			pair_q    <= '0;
			done      <= 1'b0;
		end else begin
			done <= cmd.result_out || cmd.trivial_out;
			if (cmd.clear_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.capture) begin
				started_q <= 1'b1;
			end
			if (cmd.hist_upd) begin
				if (grow) begin
					pair_q <= pair_q + PAIR_W'(hist_rd_q);
				end else begin
					pair_q <= pair_q - PAIR_W'(hist_new);
				end
				unique case (cur_move_q)
					MV_GROW_HIGH:   whi_q <= whi_q + W_ONE;
					MV_GROW_LOW:    wlo_q <= wlo_q - W_ONE;
					MV_SHRINK_HIGH: whi_q <= whi_q - W_ONE;
					MV_SHRINK_LOW:  wlo_q <= wlo_q + W_ONE;
					default: ;
				endcase
			end
		end
	end

	assign rn_sh = {rn_q[PAIR_W-1:0], num_q[bit_q]};
	assign rd_sh = {rd_q[PAIR_W-1:0], den_q[bit_q]};

	// Query payload, gcd by subtraction and long division by the gcd.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			lq_q      <= SA'(lsat);
			rq_q      <= SA'(rsat);
			err_q     <= in_item.left > in_item.right;
			trivial_q <= (in_item.left > in_item.right) || (lsat == rsat);
		end
		if (cmd.seq_rd) begin
			cur_move_q <= move_q;
		end
		if (cmd.hist_rd) begin
			val_q <= VA'(seq_rd_q);
		end
		if (cmd.den_calc) begin
			den_q <= PAIR_W'(((32'(rq_q - lq_q) + 1) * 32'(rq_q - lq_q)) >> 1);
			num_q <= pair_q;
			ga_q  <= pair_q;
			gb_q  <= PAIR_W'(((32'(rq_q - lq_q) + 1) * 32'(rq_q - lq_q)) >> 1);
		end
		if (cmd.gcd_step) begin
			if (ga_q == '0) begin
				ga_q <= gb_q;
				gb_q <= '0;
			end else if (ga_q >= gb_q) begin
				if (ga_q - gb_q < gb_q) begin
					ga_q <= gb_q;
					gb_q <= ga_q - gb_q;
				end else begin
					ga_q <= ga_q - gb_q;
				end
			end else begin
				ga_q <= gb_q;
				gb_q <= ga_q;
			end
		end
		if (cmd.div_init) begin
			g_q   <= ga_q;
			rn_q  <= '0;
			rd_q  <= '0;
			bit_q <= 5'(PAIR_W - 1);
		end
		if (cmd.div_step) begin
			if (rn_sh >= {1'b0, g_q}) begin
				rn_q <= rn_sh - {1'b0, g_q};
				qn_q[bit_q] <= 1'b1;
			end else begin
				rn_q <= rn_sh;
				qn_q[bit_q] <= 1'b0;
			end
			if (rd_sh >= {1'b0, g_q}) begin
				rd_q <= rd_sh - {1'b0, g_q};
				qd_q[bit_q] <= 1'b1;
			end else begin
				rd_q <= rd_sh;
				qd_q[bit_q] <= 1'b0;
			end
			bit_q <= bit_q - 1'b1;
		end
		if (cmd.div_init) begin
			gdone_q <= 1'b0;
		end else if (cmd.div_step && bit_q == '0) begin
			gdone_q <= 1'b1;
		end
		if (cmd.result_out) begin
			res.numerator   <= qn_q;
			res.denominator <= qd_q;
			res.range_error <= 1'b0;
		end else if (cmd.trivial_out) begin
			res.numerator   <= '0;
			res.denominator <= PAIR_W'(1);
			res.range_error <= err_q;
		end
	end

	always_comb begin
		stat.clear_last = (clr_q == VA'(VALUE_COUNT - 1));
		stat.move       = move_q;
		stat.trivial    = trivial_q;
		stat.gcd_done   = (gb_q == '0);
		stat.div_done   = gdone_q;
	end

`ifndef SYNTH
	a_window_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.den_calc |-> (whi_q > wlo_q))
		else $error("window empty at denominator");
	a_window_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.den_calc |-> (whi_q == $signed({2'b00, rq_q})))
		else $error("window high missed");
	a_trivial_res: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.trivial_out |=> (res.numerator == '0))
		else $error("trivial numerator");
`endif

endmodule
`default_nettype wire

// ===== rtl/range_equal_pair_counter_top.sv =====
`default_nettype none
// Equal-value pair counter over a sliding window of a loaded sequence.
// Input beat: start with busy low accepts one item from the in_item struct.
// A load (operation 0) writes one element and makes no result;
// loads after the first query are ignored.
// A query (operation 1) moves the window edges one element at a time, each
// step being a sequence read, a histogram read and a histogram update,
// then reduces the fraction: a subtractive gcd whose step count depends on the
// data (close to the denominator itself when the numerator is one) and a
// bit-serial long division by the gcd.
// The result beat appears on out_item with out_valid high for one cycle.
// Reversed and single-element ranges skip the window moves: their result is
// registered from ST_MOVE_RD, and new input is taken again after ST_DONE.
// After reset the histogram memory is swept to zero with busy high; the receiver
// cannot stall, so results are never held.
module range_equal_pair_counter_top
	import repc_pkg::*;
#(
	parameter int SEQ_DEPTH   = 4096,
	parameter int VALUE_COUNT = 4096
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire repc_in_t in_item,
	output logic          busy,
	output logic          out_valid,
	output repc_out_t     out_item
);

	repc_cmd_t  cmd;
	repc_stat_t stat;

	repc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (in_item.operation),
		.stat      (stat),
		.busy      (busy),
		.cmd       (cmd)
	);

	repc_dp #(
		.SEQ_DEPTH   (SEQ_DEPTH),
		.VALUE_COUNT (VALUE_COUNT)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_item),
		.cmd     (cmd),
		.stat    (stat),
		.done    (out_valid),
		.res     (out_item)
	);

endmodule
`default_nettype wire

// ===== bench/tb_range_equal_pair_counter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_range_equal_pair_counter_top;
	import repc_pkg::*;

	// Every position below this bound is loaded; queries over more than one element stay below it.
	localparam int LOADED = 128;
	localparam int STORE_DEPTH = 4096;

	logic      clk;
	logic      arst_n;
	logic      start;
	repc_in_t  in_item;
	logic      busy;
	logic      out_valid;
	repc_out_t out_item;

	range_equal_pair_counter_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.in_item(in_item),
		.busy(busy),
		.out_valid(out_valid),
		.out_item(out_item)
	);

	// Private copy of the block state used to predict each answer.
	logic [11:0] seq_copy [STORE_DEPTH];
	logic [12:0] color_hist [STORE_DEPTH];
	logic [22:0] equal_pairs;
	int          win_lo;
	int          win_hi;
	bit          queried;

	repc_out_t   pending_answers[$];
	int          mismatches;
	int          burst_left;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("end of test: mismatches");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic logic [22:0] gcd23(input logic [22:0] a, input logic [22:0] b);
		logic [22:0] t;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		return a;
	endfunction

	function automatic void hist_add(input int pos);
		logic [11:0] c;
		c = seq_copy[pos];
		equal_pairs = equal_pairs + color_hist[c];
		color_hist[c] = color_hist[c] + 1'b1;
	endfunction

	function automatic void hist_del(input int pos);
		logic [11:0] c;
		c = seq_copy[pos];
		color_hist[c] = color_hist[c] - 1'b1;
		equal_pairs = equal_pairs - color_hist[c];
	endfunction

	// Computes the answer for one accepted beat; loads give none.
	function automatic void predict_beat(input repc_in_t it);
		repc_out_t   ans;
		int          lq;
		int          rq;
		int          span;
		logic [22:0] den;
		logic [22:0] g;
		if (it.operation == OP_LOAD) begin
			if (!queried) seq_copy[it.position] = it.value;
			return;
		end
		queried = 1'b1;
		ans = '0;
		ans.denominator = 23'd1;
		lq = it.left;
		rq = it.right;
		if (lq > rq) begin
			ans.range_error = 1'b1;
		end else if (lq != rq) begin
			while (win_hi < rq) begin win_hi++; hist_add(win_hi); end
			while (win_lo > lq) begin win_lo--; hist_add(win_lo); end
			while (win_hi > rq) begin hist_del(win_hi); win_hi--; end
			while (win_lo < lq) begin hist_del(win_lo); win_lo++; end
			span = rq - lq;
			den = 23'(((span + 1) * span) >> 1);
			g = gcd23(equal_pairs, den);
			ans.numerator = equal_pairs / g;
			ans.denominator = den / g;
		end
		pending_answers.push_back(ans);
	endfunction

	// Sends one beat, holding start until accepted; beats go in bursts with idle gaps between.
	task automatic send_item(input repc_in_t it);
		start <= 1'b1;
		in_item <= it;
		// The beat is taken at the first rising edge that follows a cycle with busy low.
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		predict_beat(it);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
		end else begin
			burst_left--;
		end
	endtask

	function automatic repc_in_t rand_item(input logic op);
		repc_in_t it;
		it = ($bits(repc_in_t))'({$urandom, $urandom});
		it.operation = op;
		return it;
	endfunction

	function automatic repc_in_t make_query(input int l, input int r);
		repc_in_t it;
		it = rand_item(OP_QUERY);
		it.left = 12'(l);
		it.right = 12'(r);
		return it;
	endfunction

	// Each result beat is compared with the oldest pending answer.
	always @(posedge clk) begin
		if (arst_n && out_valid) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				repc_out_t want;
				want = pending_answers.pop_front();
				if (out_item.numerator != want.numerator)
					report_mismatch("numerator", out_item.numerator, want.numerator);
				if (out_item.denominator != want.denominator)
					report_mismatch("denominator", out_item.denominator, want.denominator);
				if (out_item.range_error != want.range_error)
					report_mismatch("range_error", out_item.range_error, want.range_error);
			end
		end
	end

	// Fills every position below LOADED, with extremes, rewrites and stray positions.
	task automatic test_load_phase();
		repc_in_t it;
		for (int p = 0; p < LOADED; p++) begin
			it = rand_item(OP_LOAD);
			it.position = 12'(p);
			it.value = (p == 0) ? 12'd0 : (p == 1) ? 12'd4095 : 12'($urandom_range(0, 7));
			send_item(it);
		end
		for (int k = 0; k < 20; k++) begin
			it = rand_item(OP_LOAD);
			if (k < 8) it.position = 12'($urandom_range(0, LOADED - 1));
			if (k == 10) it.position = 12'd4095;
			if (k < 4) it.value = 12'($urandom_range(0, 3));
			send_item(it);
		end
	endtask

	task automatic test_directed_queries();
		send_item(make_query(4095, 0));
		send_item(make_query(4095, 4095));
		send_item(make_query(0, 0));
		send_item(make_query(0, 1));
		send_item(make_query(0, LOADED - 1));
		send_item(make_query(LOADED - 2, LOADED - 1));
		send_item(make_query(10, 20));
		send_item(make_query(30, 60));
		send_item(make_query(5, 15));
		send_item(make_query(1, 0));
		send_item(make_query(2048, 2047));
	endtask

	// Loads after the first query must leave the stored sequence untouched.
	task automatic test_late_loads();
		repc_in_t it;
		for (int k = 0; k < 10; k++) begin
			it = rand_item(OP_LOAD);
			if (k < 6) it.position = 12'($urandom_range(0, LOADED - 1));
			send_item(it);
		end
		send_item(make_query(0, LOADED - 1));
	endtask

	task automatic test_random_queries(input int count);
		int sel;
		int l;
		int r;
		int t;
		for (int k = 0; k < count; k++) begin
			sel = $urandom_range(0, 19);
			if (sel == 0) begin
				l = $urandom_range(1, 4095);
				r = $urandom_range(0, l - 1);
			end else if (sel == 1) begin
				l = $urandom_range(0, 4095);
				r = l;
			end else if (sel == 2) begin
				send_item(rand_item(OP_LOAD));
				continue;
			end else begin
				l = $urandom_range(0, LOADED - 1);
				r = (sel < 8) ? l + $urandom_range(0, 6) : $urandom_range(0, LOADED - 1);
				if (r > LOADED - 1) r = LOADED - 1;
				if (l > r) begin t = l; l = r; r = t; end
			end
			send_item(make_query(l, r));
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		in_item <= '0;
		mismatches = 0;
		burst_left = 0;
		queried = 1'b0;
		equal_pairs = '0;
		win_lo = 0;
		win_hi = -1;
		foreach (color_hist[i]) color_hist[i] = '0;
		foreach (seq_copy[i]) seq_copy[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_load_phase();
		test_directed_queries();
		test_late_loads();
		test_random_queries(440);

		start <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/repc_pkg.sv
rtl/repc_ctrl.sv
rtl/repc_dp.sv
rtl/range_equal_pair_counter_top.sv
bench/tb_range_equal_pair_counter_top.sv
